[rtl/esl_pkg.sv]
// ---------------------------------------------------------------------------
// esl_pkg
// Shared types, codes and helpers for the elevator stop-list controller.
// ---------------------------------------------------------------------------
`default_nettype none

package esl_pkg;

  localparam int unsigned MaxStops   = 16;
  localparam int unsigned FloorW     = 6;
  localparam int unsigned DistW      = 12;
  localparam int unsigned CntW       = $clog2(MaxStops + 1);
  localparam int unsigned IdxW       = $clog2(MaxStops);
  localparam int unsigned FloorCfgW  = 7;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
  localparam logic [FloorCfgW-1:0] FloorCountRst = 7'd16;

  localparam logic [1:0] ReqTick = 2'd0;
  localparam logic [1:0] ReqAdd  = 2'd1;
  localparam logic [1:0] ReqAsk  = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatPlanned = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatRange   = 2'd3;

  localparam logic signed [1:0] DirIdle = 2'sb00;
  localparam logic signed [1:0] DirUp   = 2'sb01;
  localparam logic signed [1:0] DirDown = 2'sb11;

  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellShift  = 2'd1,
    CellInsert = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [CntW-1:0]   idx;
    logic [FloorW-1:0] fl;
  } cell_ctrl_t;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StDrop    = 6'b000010,
    StWalk    = 6'b000100,
    StRestore = 6'b001000,
    StApply   = 6'b010000,
    StDone    = 6'b100000
  } state_e;

  function automatic logic [FloorW-1:0] abs_diff(input logic [FloorW-1:0] a,
                                                 input logic [FloorW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DistW-1:0] sat_add(input logic [DistW-1:0] a,
                                               input logic [FloorW-1:0] b);
    logic [DistW:0] s;
    s = {1'b0, a} + {{(DistW + 1 - FloorW){1'b0}}, b};
    sat_add = s[DistW] ? DistMax : s[DistW-1:0];
  endfunction

  function automatic logic between(input logic [FloorW-1:0] a,
                                   input logic [FloorW-1:0] b,
                                   input logic [FloorW-1:0] c);
    between = ((a <= b) && (b <= c)) || ((a >= b) && (b >= c));
  endfunction

endpackage

`default_nettype wire

[rtl/esl_cell.sv]
// ---------------------------------------------------------------------------
// esl_cell
// One stop slot of the ring: holds, takes its right neighbor, or inserts.
// ---------------------------------------------------------------------------
`default_nettype none

module esl_cell (
  input  wire logic                          clk_i,
  input  wire esl_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [esl_pkg::IdxW-1:0]      my_idx_i,
  input  wire logic [esl_pkg::FloorW-1:0]    left_i,
  input  wire logic [esl_pkg::FloorW-1:0]    right_i,
  output      logic [esl_pkg::FloorW-1:0]    floor_o
);

  logic [esl_pkg::FloorW-1:0] floor_q, floor_d;
  logic [esl_pkg::CntW-1:0]   me;

  assign me = {1'b0, my_idx_i};

  always_comb begin
    floor_d = floor_q;
    case (ctrl_i.op)
      esl_pkg::CellShift: floor_d = right_i;
      esl_pkg::CellInsert: begin
        if (ctrl_i.idx == me) floor_d = ctrl_i.fl;
        else if (ctrl_i.idx < me) floor_d = left_i;
      end
      default: floor_d = floor_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    floor_q <= floor_d;
  end

  assign floor_o = floor_q;

endmodule

`default_nettype wire

[rtl/elevator_stop_list_controller_unit.sv]
// ---------------------------------------------------------------------------
// elevator_stop_list_controller_unit
// Car state and ordered stop list held in a ring of stop cells.
// ---------------------------------------------------------------------------
// One request at a time. A tick moves the car, then drops the reached stops
// from the head one by one. Add/ask is settled without a walk when the answer
// is found against the car floor or the first stop (or the floor is out of
// range), inserting there if needed; otherwise the stop ring is walked by
// rotating all 16 cells once around. The ring rotation, one cell per cycle,
// sets the latency. The finished result is held in an output register, so a
// new request may enter while it waits.
`default_nettype none

module elevator_stop_list_controller_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [esl_pkg::FloorCfgW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [esl_pkg::FloorW-1:0]      target_floor_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [esl_pkg::FloorW-1:0]      car_floor_o,
  output      logic signed [1:0]               car_direction_o,
  output      logic [esl_pkg::DistW-1:0]       travel_distance_o,
  output      logic [1:0]                      status_o,
  output      logic [esl_pkg::CntW-1:0]        stops_pending_o
);

  esl_pkg::state_e state_q, state_d;
  logic [esl_pkg::FloorCfgW-1:0] fcount_q;
  logic [esl_pkg::FloorW-1:0]    pos_q, pos_d, tgt_q, tgt_d;
  logic signed [1:0]             dir_q, dir_d;
  logic [esl_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic [1:0]                    req_q, req_d;
  logic [esl_pkg::FloorW-1:0]    fl_q, fl_d;
  logic [esl_pkg::DistW-1:0]     dist_q, dist_d;
  logic [1:0]                    stat_q, stat_d;
  logic [esl_pkg::CntW-1:0]      idx_q, idx_d;
  logic                          ins_q, ins_d;
  logic [esl_pkg::IdxW-1:0]      step_q, step_d;
  logic                          ov_q;

  logic [esl_pkg::FloorW-1:0] cell_fl [esl_pkg::MaxStops];
  esl_pkg::cell_ctrl_t        ctrl;
  logic [esl_pkg::FloorW-1:0] c0, c1, p1;
  logic [esl_pkg::CntW-1:0]   step_nx;
  logic                       accept, load_out;

  assign c0 = cell_fl[0];
  assign c1 = cell_fl[1];
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == esl_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign load_out = (state_q == esl_pkg::StDone) && (!ov_q || out_ready_i);
  assign step_nx = {1'b0, step_q} + 1'b1;
  assign p1 = pos_q + {{(esl_pkg::FloorW-2){dir_q[1]}}, dir_q};

  for (genvar k = 0; k < esl_pkg::MaxStops; k++) begin : g_cell
    esl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .my_idx_i(esl_pkg::IdxW'(k)),
      .left_i  (cell_fl[(k + esl_pkg::MaxStops - 1) % esl_pkg::MaxStops]),
      .right_i (cell_fl[(k + 1) % esl_pkg::MaxStops]),
      .floor_o (cell_fl[k])
    );
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q; tgt_d = tgt_q; dir_d = dir_q; cnt_d = cnt_q;
    req_d = req_q; fl_d = fl_q; dist_d = dist_q; stat_d = stat_q;
    idx_d = idx_q; ins_d = ins_q; step_d = step_q;
    ctrl.op = esl_pkg::CellHold;
    ctrl.idx = idx_q;
    ctrl.fl = fl_q;
    case (state_q)
      esl_pkg::StIdle: begin
        if (accept) begin
          req_d = req_type_i; fl_d = target_floor_i;
          dist_d = '0; stat_d = esl_pkg::StatOk; ins_d = 1'b0;
          idx_d = '0; step_d = '0;
          state_d = esl_pkg::StDone;
          if (req_type_i == esl_pkg::ReqTick) begin
            pos_d = p1;
            if (((dir_q == esl_pkg::DirUp) && (p1 >= tgt_q)) ||
                ((dir_q == esl_pkg::DirDown) && (p1 <= tgt_q))) begin
              pos_d = tgt_q;
              dir_d = esl_pkg::DirIdle;
            end
            state_d = esl_pkg::StDrop;
          end else if (req_type_i == esl_pkg::ReqAdd ||
                       req_type_i == esl_pkg::ReqAsk) begin
            if ({1'b0, target_floor_i} >= fcount_q) begin
              stat_d = esl_pkg::StatRange;
            end else if (cnt_q == '0) begin
              dist_d = esl_pkg::sat_add('0, esl_pkg::abs_diff(pos_q, target_floor_i));
              ins_d = 1'b1;
              state_d = esl_pkg::StApply;
            end else if (target_floor_i == pos_q) begin
              stat_d = esl_pkg::StatPlanned;
            end else if (target_floor_i == c0) begin
              dist_d = esl_pkg::sat_add('0, esl_pkg::abs_diff(c0, pos_q));
              stat_d = esl_pkg::StatPlanned;
            end else if (esl_pkg::between(pos_q, target_floor_i, c0)) begin
              dist_d = esl_pkg::sat_add('0, esl_pkg::abs_diff(target_floor_i, pos_q));
              ins_d = 1'b1;
              state_d = esl_pkg::StApply;
            end else begin
              dist_d = esl_pkg::sat_add('0, esl_pkg::abs_diff(c0, pos_q));
              state_d = esl_pkg::StWalk;
            end
          end
        end
      end
      esl_pkg::StDrop: begin
        if (cnt_q != '0 && c0 == pos_q) begin
          ctrl.op = esl_pkg::CellShift;
          cnt_d = cnt_q - 1'b1;
        end else begin
          if (dir_q == esl_pkg::DirIdle && cnt_q != '0) begin
            tgt_d = c0;
            dir_d = (c0 > pos_q) ? esl_pkg::DirUp :
                    (c0 < pos_q) ? esl_pkg::DirDown : esl_pkg::DirIdle;
          end
          state_d = esl_pkg::StDone;
        end
      end
      esl_pkg::StWalk: begin
        ctrl.op = esl_pkg::CellShift;
        step_d = step_q + 1'b1;
        if (fl_q == c0 || (step_nx < cnt_q && fl_q == c1)) begin
          dist_d = esl_pkg::sat_add(dist_q, esl_pkg::abs_diff(fl_q, c0));
          stat_d = esl_pkg::StatPlanned;
          state_d = esl_pkg::StRestore;
        end else if (step_nx >= cnt_q || esl_pkg::between(c0, fl_q, c1)) begin
          dist_d = esl_pkg::sat_add(dist_q, esl_pkg::abs_diff(fl_q, c0));
          idx_d = step_nx;
          ins_d = 1'b1;
          state_d = esl_pkg::StRestore;
        end else begin
          dist_d = esl_pkg::sat_add(dist_q, esl_pkg::abs_diff(c1, c0));
        end
      end
      esl_pkg::StRestore: begin
        if (step_q != '0) begin
          ctrl.op = esl_pkg::CellShift;
          step_d = step_q + 1'b1;
        end else begin
          state_d = esl_pkg::StApply;
        end
      end
      esl_pkg::StApply: begin
        if (ins_q && req_q == esl_pkg::ReqAdd) begin
          if (cnt_q >= esl_pkg::CntW'(esl_pkg::MaxStops)) begin
            stat_d = esl_pkg::StatFull;
          end else begin
            ctrl.op = esl_pkg::CellInsert;
            cnt_d = cnt_q + 1'b1;
          end
        end
        state_d = esl_pkg::StDone;
      end
      esl_pkg::StDone: begin
        if (load_out) state_d = esl_pkg::StIdle;
      end
      default: state_d = esl_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= esl_pkg::StIdle;
      fcount_q <= esl_pkg::FloorCountRst;
      pos_q <= '0; tgt_q <= '0; dir_q <= esl_pkg::DirIdle; cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d; tgt_q <= tgt_d; dir_q <= dir_d; cnt_q <= cnt_d;
      if (cfg_valid_i) fcount_q <= cfg_data_i;
      if (load_out) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; fl_q <= fl_d; dist_q <= dist_d; stat_q <= stat_d;
    idx_q <= idx_d; ins_q <= ins_d; step_q <= step_d;
    if (load_out) begin
      car_floor_o <= pos_q;
      car_direction_o <= dir_q;
      travel_distance_o <= dist_q;
      status_o <= stat_q;
      stops_pending_o <= cnt_q;
    end
  end

  assign out_valid_o = ov_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= esl_pkg::CntW'(esl_pkg::MaxStops)) else $error("stop count overflow");
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == esl_pkg::StWalk |-> cnt_q != '0) else $error("walk on empty list");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o && state_q == esl_pkg::StIdle)
    else $error("result not presented");

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the elevator stop-list controller. Drives tick,
// add and ask requests through the valid/ready ports, predicts each result
// from a behavioral model of the car and its stop list, and compares every
// output field in order of arrival. Floor count is changed between phases.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Limit = 400000;
  localparam logic [1:0] ReqIgnored = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [esl_pkg::FloorCfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [esl_pkg::FloorW-1:0] target_floor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [esl_pkg::FloorW-1:0] car_floor;
  logic signed [1:0] car_direction;
  logic [esl_pkg::DistW-1:0] travel_distance;
  logic [1:0] status;
  logic [esl_pkg::CntW-1:0] stops_pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  elevator_stop_list_controller_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .target_floor_i(target_floor),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .car_floor_o(car_floor), .car_direction_o(car_direction),
    .travel_distance_o(travel_distance), .status_o(status),
    .stops_pending_o(stops_pending)
  );

  typedef struct packed {
    logic [esl_pkg::FloorW-1:0] fl;
    logic signed [1:0] dir;
    logic [esl_pkg::DistW-1:0] trav;
    logic [1:0] stat;
    logic [esl_pkg::CntW-1:0] cnt;
  } car_report_t;

  car_report_t expected_reports[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // car model
  int fc_m = esl_pkg::FloorCountRst;
  int pos_m = 0;
  int tgt_m = 0;
  int dir_m = 0;
  int stops_m[$];

  function automatic int dabs(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int sat(int a, int b);
    return (a + b > 4095) ? 4095 : a + b;
  endfunction

  function automatic bit lies_on(int a, int b, int c);
    return (a <= b && b <= c) || (a >= b && b >= c);
  endfunction

  function automatic void move_car();
    pos_m += dir_m;
    if ((dir_m > 0 && pos_m >= tgt_m) || (dir_m < 0 && pos_m <= tgt_m)) begin
      pos_m = tgt_m;
      dir_m = 0;
    end
    while (stops_m.size() > 0 && stops_m[0] == pos_m) stops_m.delete(0);
    if (dir_m == 0 && stops_m.size() > 0) begin
      tgt_m = stops_m[0];
      dir_m = tgt_m > pos_m ? 1 : (tgt_m < pos_m ? -1 : 0);
    end
  endfunction

  function automatic car_report_t predict_car(logic [1:0] rq, int fl);
    car_report_t r;
    int trav, st, n, idx, i, lim;
    trav = 0; st = esl_pkg::StatOk; idx = -1;
    n = stops_m.size();
    lim = fc_m < 64 ? fc_m : 64;
    if (rq == esl_pkg::ReqTick) move_car();
    else if (rq == esl_pkg::ReqAdd || rq == esl_pkg::ReqAsk) begin
      if (fl >= lim) st = esl_pkg::StatRange;
      else if (n == 0) begin
        trav = dabs(pos_m, fl); idx = 0;
      end else if (fl == pos_m) st = esl_pkg::StatPlanned;
      else if (fl == stops_m[0]) begin
        trav = dabs(stops_m[0], pos_m); st = esl_pkg::StatPlanned;
      end else if (lies_on(pos_m, fl, stops_m[0])) begin
        trav = dabs(fl, pos_m); idx = 0;
      end else begin
        i = 0;
        trav = dabs(stops_m[0], pos_m);
        forever begin
          if (fl == stops_m[i] || (i + 1 < n && fl == stops_m[i+1])) begin
            trav = sat(trav, dabs(fl, stops_m[i])); st = esl_pkg::StatPlanned; break;
          end
          if (i + 1 >= n) begin
            trav = sat(trav, dabs(fl, stops_m[i])); idx = n; break;
          end
          if (lies_on(stops_m[i], fl, stops_m[i+1])) begin
            trav = sat(trav, dabs(fl, stops_m[i])); idx = i + 1; break;
          end
          trav = sat(trav, dabs(stops_m[i+1], stops_m[i]));
          i++;
        end
      end
      if (idx >= 0 && rq == esl_pkg::ReqAdd) begin
        if (n >= esl_pkg::MaxStops) st = esl_pkg::StatFull;
        else stops_m.insert(idx, fl);
      end
    end
    r.fl = pos_m[esl_pkg::FloorW-1:0];
    r.dir = dir_m[1:0];
    r.trav = trav[esl_pkg::DistW-1:0];
    r.stat = st[1:0];
    r.cnt = esl_pkg::CntW'(stops_m.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // valid is dropped only while idling; drain() drops it between phases and at the end
  task automatic send_request(logic [1:0] rq, logic [esl_pkg::FloorW-1:0] fl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    target_floor <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_reports.insert(expected_reports.size(), predict_car(rq, fl));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_reports.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_floor_count(int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[esl_pkg::FloorCfgW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fc_m = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    car_report_t w;
    cycles++;
    if (cycles > Limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        w = expected_reports[0];
        expected_reports.delete(0);
        if (car_floor !== w.fl) report_mismatch("car_floor", car_floor, w.fl);
        if (car_direction !== w.dir) report_mismatch("car_direction", car_direction, w.dir);
        if (travel_distance !== w.trav)
          report_mismatch("travel_distance", travel_distance, w.trav);
        if (status !== w.stat) report_mismatch("status", status, w.stat);
        if (stops_pending !== w.cnt) report_mismatch("stops_pending", stops_pending, w.cnt);
      end
    end
  end

  task automatic test_directed();
    send_request(esl_pkg::ReqTick, 0);
    send_request(esl_pkg::ReqAdd, 0);
    send_request(esl_pkg::ReqTick, 0);
    send_request(esl_pkg::ReqAdd, 15);
    send_request(esl_pkg::ReqAdd, 16);
    send_request(esl_pkg::ReqAsk, 63);
    send_request(esl_pkg::ReqAdd, 5);
    send_request(esl_pkg::ReqAdd, 0);
    send_request(esl_pkg::ReqAdd, 15);
    send_request(esl_pkg::ReqAdd, 10);
    send_request(esl_pkg::ReqAsk, 12);
    send_request(esl_pkg::ReqAsk, 3);
    send_request(ReqIgnored, 7);
    repeat (4) send_request(esl_pkg::ReqTick, 0);
    send_request(esl_pkg::ReqAdd, 2);
    repeat (20) send_request(esl_pkg::ReqTick, 0);
  endtask

  task automatic test_full_list();
    for (int k = 0; k < 18; k++) send_request(esl_pkg::ReqAdd, (k * 7) % 16);
    send_request(esl_pkg::ReqAsk, 15);
    send_request(esl_pkg::ReqAdd, 1);
    send_request(esl_pkg::ReqAsk, 9);
    repeat (60) send_request(esl_pkg::ReqTick, 0);
  endtask

  task automatic test_random(int count, int fc);
    logic [1:0] rq;
    int fl;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: rq = esl_pkg::ReqTick;
        4, 5, 6: rq = esl_pkg::ReqAdd;
        7, 8: rq = esl_pkg::ReqAsk;
        default: rq = ReqIgnored;
      endcase
      fl = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(fc - 1);
      send_request(rq, fl[esl_pkg::FloorW-1:0]);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_list();
    write_floor_count(64);
    test_random(130, 64);
    send_idle_pct = 56;
    write_floor_count(2);
    test_random(60, 2);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    write_floor_count(127);
    send_request(esl_pkg::ReqAsk, 63);
    test_random(120, 64);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    write_floor_count(20);
    test_random(130, 20);
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
